// File: sv/mgm_pkg.sv
// ---------------------------------------------------------------------------
// mgm_pkg: shared types and field arithmetic for the masked GF(2^8) multiplier
// Lane records carried between pipeline stages and the AES-field product.
// ---------------------------------------------------------------------------
package mgm_pkg;

    localparam int SHARES_DEF = 3;
    localparam int BYTE_W     = 8;
    localparam int RAND_WORDS = 5;
    localparam int RAND_W     = RAND_WORDS * 64;
    localparam int T_BYTES    = 2;          // top-level remask bytes t0, t1

    // x^8 + x^4 + x^3 + x + 1, low byte
    localparam logic [BYTE_W-1:0] RED_POLY = 8'h1B;

    typedef logic [BYTE_W-1:0] mgm_byte_t;

    // One lane: two products x0*y0 and x1*y1, plus the masks folded in after
    typedef struct packed {
        mgm_byte_t x0;
        mgm_byte_t y0;
        mgm_byte_t x1;
        mgm_byte_t y1;
        mgm_byte_t mk0;
        mgm_byte_t mk1;
        mgm_byte_t tk;
    } mgm_lane_t;

    typedef struct packed {
        mgm_byte_t m0;
        mgm_byte_t m1;
        mgm_byte_t mk0;
        mgm_byte_t mk1;
        mgm_byte_t tk;
    } mgm_prod_t;

    function automatic mgm_byte_t gf_mul(input mgm_byte_t x, input mgm_byte_t y);
        mgm_byte_t acc;
        mgm_byte_t xs;
        acc = '0;
        xs  = x;
        for (int i = 0; i < BYTE_W; i++) begin
            if (y[i]) begin
                acc = acc ^ xs;
            end
            xs = {xs[BYTE_W-2:0], 1'b0} ^ (xs[BYTE_W-1] ? RED_POLY : '0);
        end
        return acc;
    endfunction

endpackage

// File: sv/masked_gf256_multiply.sv
// ---------------------------------------------------------------------------
// masked_gf256_multiply: masked multiplication in the AES field
// Pipeline: 3 register stages; an accepted request passes the remask, multiply
// and compress registers in that order, and the compress register drives m_valid.
// Throughput: one request per cycle while the output side takes results.
// Each stage holds while its successor is full, so back-pressure loses nothing.
// Reset (aresetn low, synchronous) empties every stage; payloads are not reset.
// ---------------------------------------------------------------------------
module masked_gf256_multiply import mgm_pkg::*; #(
    parameter int SHARES = SHARES_DEF       // 2 to 4 shares
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [BYTE_W*SHARES-1:0]    s_a_shares,
    input  logic [BYTE_W*SHARES-1:0]    s_b_shares,
    input  logic [63:0]                 s_rand0,
    input  logic [63:0]                 s_rand1,
    input  logic [63:0]                 s_rand2,
    input  logic [63:0]                 s_rand3,
    input  logic [63:0]                 s_rand4,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [BYTE_W*SHARES-1:0]    m_c_shares
);

    // Random byte k sits at bits 8k+7:8k of the joined word. Bytes 0 and 1
    // are the top-level masks; the sub-gadget bytes follow per output share,
    // four per pair of b shares, ten for the closing triple when SHARES is odd.
    logic [RAND_W-1:0] rnd;
    assign rnd = {s_rand4, s_rand3, s_rand2, s_rand1, s_rand0};

    // Lanes: SHARES per output share. A pair gives two lanes, a triple three,
    // and every lane carries exactly two products, so all stages stay uniform.
    mgm_lane_t [SHARES*SHARES-1:0] s1_lanes;
    mgm_prod_t [SHARES*SHARES-1:0] s2_prods;
    logic                          s1_valid, s1_ready;
    logic                          s2_valid, s2_ready;

    // Stage 1: remask a and b shares with the sub-gadget randoms
    mgm_remask #(.SHARES(SHARES)) u_remask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .a_shares  (s_a_shares),
        .b_shares  (s_b_shares),
        .rnd       (rnd),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_lanes (s1_lanes)
    );

    // Stage 2: field products, registered straight after the multipliers
    mgm_mult #(.SHARES(SHARES)) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_lanes  (s1_lanes),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_prods (s2_prods)
    );

    // Stage 3: output remask and per-share sum; this register is the output
    mgm_compress #(.SHARES(SHARES)) u_compress (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_prods  (s2_prods),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .c_shares  (m_c_shares)
    );

    // Input only stalls when every stage is full, so the output must be holding
    a_stall_needs_full_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while output stage empty");

    // A result only appears if the multiply stage held a request
    a_out_from_mult: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s2_valid))
        else $error("output valid without a preceding product");

    a_mult_from_remask: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s2_valid) |-> $past(s1_valid))
        else $error("product valid without a preceding remask");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s1_valid && !s2_valid)
        else $error("pipeline not empty after reset");

endmodule

// File: sv/mgm_remask.sv
// ---------------------------------------------------------------------------
// mgm_remask: first stage, input remasking
// Builds the remasked operand pairs and mask bytes of every sub-gadget lane.
// ---------------------------------------------------------------------------
module mgm_remask import mgm_pkg::*; #(
    parameter int SHARES = SHARES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [BYTE_W*SHARES-1:0]        a_shares,
    input  logic [BYTE_W*SHARES-1:0]        b_shares,
    input  logic [RAND_W-1:0]               rnd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mgm_lane_t [SHARES*SHARES-1:0]   out_lanes
);

    localparam int NG        = SHARES / 2;
    localparam int ODD       = SHARES % 2;
    localparam int PER_SHARE = 4 * (NG - ODD) + 10 * ODD;

    logic                          valid_reg, valid_next;
    mgm_lane_t [SHARES*SHARES-1:0] lanes_reg, lanes_next;
    mgm_byte_t                     t0, t1;

    assign t0 = rnd[0 +: BYTE_W];
    assign t1 = rnd[BYTE_W +: BYTE_W];

    for (genvar p = 0; p < SHARES; p++) begin : g_share
        mgm_byte_t ap;
        assign ap = a_shares[BYTE_W*p +: BYTE_W];

        for (genvar l = 0; l < SHARES; l++) begin : g_lane
            localparam int G    = ((l / 2) < NG) ? (l / 2) : (NG - 1);
            localparam int TRI  = ((ODD == 1) && (G == NG - 1)) ? 1 : 0;
            localparam int J    = l - 2 * G;
            localparam int BASE = T_BYTES + p * PER_SHARE + 4 * G;

            if (TRI != 0) begin : g_tri
                localparam int JN = (J + 1) % 3;
                mgm_byte_t u, uu, v;
                mgm_byte_t r6, r7, r8, r9;
                assign r6 = rnd[BYTE_W*(BASE+6) +: BYTE_W];
                assign r7 = rnd[BYTE_W*(BASE+7) +: BYTE_W];
                assign r8 = rnd[BYTE_W*(BASE+8) +: BYTE_W];
                assign r9 = rnd[BYTE_W*(BASE+9) +: BYTE_W];
                assign u  = ap ^ rnd[BYTE_W*(BASE+J) +: BYTE_W]
                               ^ rnd[BYTE_W*(BASE+JN) +: BYTE_W];
                assign uu = u ^ ap;
                assign v  = b_shares[BYTE_W*(2*G+J) +: BYTE_W]
                          ^ rnd[BYTE_W*(BASE+3+J) +: BYTE_W]
                          ^ rnd[BYTE_W*(BASE+3+JN) +: BYTE_W];
                always_comb begin
                    lanes_next[p*SHARES+l].x0 = u;
                    lanes_next[p*SHARES+l].y0 = v;
                    lanes_next[p*SHARES+l].x1 = uu;
                    lanes_next[p*SHARES+l].y1 = v;
                    case (J)
                        0: begin
                            lanes_next[p*SHARES+l].mk0 = r6;
                            lanes_next[p*SHARES+l].mk1 = r7;
                            lanes_next[p*SHARES+l].tk  = t0;
                        end
                        1: begin
                            lanes_next[p*SHARES+l].mk0 = r8;
                            lanes_next[p*SHARES+l].mk1 = r9;
                            lanes_next[p*SHARES+l].tk  = t1;
                        end
                        default: begin
                            lanes_next[p*SHARES+l].mk0 = r6 ^ r8;
                            lanes_next[p*SHARES+l].mk1 = r7 ^ r9;
                            lanes_next[p*SHARES+l].tk  = t0 ^ t1;
                        end
                    endcase
                end
            end else begin : g_pair
                mgm_byte_t r0, r1, u0, u1, v0, v1;
                assign r0 = rnd[BYTE_W*BASE +: BYTE_W];
                assign r1 = rnd[BYTE_W*(BASE+1) +: BYTE_W];
                assign u0 = ap ^ r0;
                assign u1 = ap ^ u0;
                assign v0 = b_shares[BYTE_W*(2*G) +: BYTE_W] ^ r1;
                assign v1 = b_shares[BYTE_W*(2*G+1) +: BYTE_W] ^ r1;
                always_comb begin
                    lanes_next[p*SHARES+l].x0  = (J == 0) ? u0 : u1;
                    lanes_next[p*SHARES+l].y0  = v0;
                    lanes_next[p*SHARES+l].x1  = (J == 0) ? u0 : u1;
                    lanes_next[p*SHARES+l].y1  = v1;
                    lanes_next[p*SHARES+l].mk0 = rnd[BYTE_W*(BASE+2) +: BYTE_W];
                    lanes_next[p*SHARES+l].mk1 = rnd[BYTE_W*(BASE+3) +: BYTE_W];
                    lanes_next[p*SHARES+l].tk  = t0;
                end
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// File: sv/mgm_mult.sv
// ---------------------------------------------------------------------------
// mgm_mult: second stage, field products
// Two GF(2^8) products per lane; masks ride along untouched.
// ---------------------------------------------------------------------------
module mgm_mult import mgm_pkg::*; #(
    parameter int SHARES = SHARES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mgm_lane_t [SHARES*SHARES-1:0]   in_lanes,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mgm_prod_t [SHARES*SHARES-1:0]   out_prods
);

    logic                          valid_reg, valid_next;
    mgm_prod_t [SHARES*SHARES-1:0] prods_reg, prods_next;

    always_comb begin
        for (int i = 0; i < SHARES*SHARES; i++) begin
            prods_next[i].m0  = gf_mul(in_lanes[i].x0, in_lanes[i].y0);
            prods_next[i].m1  = gf_mul(in_lanes[i].x1, in_lanes[i].y1);
            prods_next[i].mk0 = in_lanes[i].mk0;
            prods_next[i].mk1 = in_lanes[i].mk1;
            prods_next[i].tk  = in_lanes[i].tk;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prods_reg <= prods_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_prods = prods_reg;

endmodule

// File: sv/mgm_compress.sv
// ---------------------------------------------------------------------------
// mgm_compress: third stage, output remask and share compression
// Folds each lane's masks into its products and sums the lanes per share.
// ---------------------------------------------------------------------------
module mgm_compress import mgm_pkg::*; #(
    parameter int SHARES = SHARES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mgm_prod_t [SHARES*SHARES-1:0]   in_prods,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [BYTE_W*SHARES-1:0]        c_shares
);

    logic                      valid_reg, valid_next;
    logic [BYTE_W*SHARES-1:0]  c_reg, c_next;

    always_comb begin
        mgm_byte_t acc;
        for (int p = 0; p < SHARES; p++) begin
            acc = '0;
            for (int l = 0; l < SHARES; l++) begin
                acc = acc ^ ((in_prods[p*SHARES+l].m0 ^ in_prods[p*SHARES+l].mk0)
                           ^ (in_prods[p*SHARES+l].m1 ^ in_prods[p*SHARES+l].mk1)
                           ^ in_prods[p*SHARES+l].tk);
            end
            c_next[BYTE_W*p +: BYTE_W] = acc;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = valid_reg;
    assign c_shares  = c_reg;

endmodule

// File: sim/masked_gf256_multiply_test.sv
// ---------------------------------------------------------------------------
// masked_gf256_multiply_test: self-checking bench for the masked multiplier
// Streams share/random requests through the block with random gaps on both
// channels and back-pressure on the result side. A scoreboard recomputes each
// masked product share by share and compares every result in request order.
// ---------------------------------------------------------------------------
module masked_gf256_multiply_test;
    import mgm_pkg::*;

    localparam int NSH         = SHARES_DEF;     // share count under test
    localparam int CW          = BYTE_W * NSH;   // width of a share vector
    localparam int RAND_BYTES  = RAND_W / BYTE_W;
    localparam int RANDOM_REQS = 1500;
    localparam int STALL_LIMIT = 2000;           // cycles without any handshake
    localparam int DRAIN_WAIT  = 8;              // pipeline is 3 deep

    // -----------------------------------------------------------------------
    // Scoreboard: keeps the product shares owed by the block, oldest first.
    // -----------------------------------------------------------------------
    class product_scoreboard;
        logic [CW-1:0]     owed_q[$];
        int unsigned       errors;
        logic [RAND_W-1:0] rnd_bits;
        int unsigned       rnd_pos;

        function new();
            errors = 0;
        endfunction

        // Field product, Horner style from the top bit of x
        function mgm_byte_t field_mul(mgm_byte_t x, mgm_byte_t y);
            mgm_byte_t prod;
            prod = '0;
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                prod = {prod[BYTE_W-2:0], 1'b0} ^ (prod[BYTE_W-1] ? RED_POLY : 8'h00);
                if (x[i]) begin
                    prod = prod ^ y;
                end
            end
            return prod;
        endfunction

        // Random bytes are drawn strictly in order; past the end they read as zero
        function mgm_byte_t next_rand_byte();
            mgm_byte_t v;
            v = '0;
            if (rnd_pos < RAND_BYTES) begin
                v = rnd_bits[BYTE_W*rnd_pos +: BYTE_W];
            end
            rnd_pos++;
            return v;
        endfunction

        // Two-share sub-gadget, folded with t0 on both outputs
        function mgm_byte_t pair_term(mgm_byte_t x, mgm_byte_t b0, mgm_byte_t b1,
                                      mgm_byte_t t0);
            mgm_byte_t r0, r1, r2, r3, u0, u1, v0, v1, k0, k1;
            r0 = next_rand_byte();
            r1 = next_rand_byte();
            r2 = next_rand_byte();
            r3 = next_rand_byte();
            u0 = x ^ r0;
            u1 = x ^ u0;
            v0 = b0 ^ r1;
            v1 = b1 ^ r1;
            k0 = (field_mul(u0, v0) ^ r2) ^ (field_mul(u0, v1) ^ r3);
            k1 = (field_mul(u1, v0) ^ r2) ^ (field_mul(u1, v1) ^ r3);
            return (k0 ^ t0) ^ (k1 ^ t0);
        endfunction

        // Three-share sub-gadget, outputs folded with t0, t1 and t0^t1
        function mgm_byte_t triple_term(mgm_byte_t x, mgm_byte_t b0, mgm_byte_t b1,
                                        mgm_byte_t b2, mgm_byte_t t0, mgm_byte_t t1);
            mgm_byte_t r[10];
            mgm_byte_t u, uu, v, k0, k1, k2;
            for (int i = 0; i < 10; i++) begin
                r[i] = next_rand_byte();
            end
            u  = x ^ r[0] ^ r[1];
            uu = u ^ x;
            v  = b0 ^ r[3] ^ r[4];
            k0 = (field_mul(u, v) ^ r[6]) ^ (field_mul(uu, v) ^ r[7]);
            u  = x ^ r[1] ^ r[2];
            uu = u ^ x;
            v  = b1 ^ r[4] ^ r[5];
            k1 = (field_mul(u, v) ^ r[8]) ^ (field_mul(uu, v) ^ r[9]);
            u  = x ^ r[2] ^ r[0];
            uu = u ^ x;
            v  = b2 ^ r[5] ^ r[3];
            k2 = (field_mul(u, v) ^ r[6] ^ r[8]) ^ (field_mul(uu, v) ^ r[7] ^ r[9]);
            return (k0 ^ t0) ^ (k1 ^ t1) ^ (k2 ^ t0 ^ t1);
        endfunction

        function logic [CW-1:0] masked_product(logic [CW-1:0] a, logic [CW-1:0] b,
                                               logic [RAND_W-1:0] rnd);
            logic [31:0] a_ext, b_ext, packed_c;
            mgm_byte_t   a_sh[4], b_sh[4];
            mgm_byte_t   t0, t1, acc;
            int          half;
            bit          odd;
            a_ext    = 32'(a);
            b_ext    = 32'(b);
            packed_c = '0;
            half     = NSH / 2;
            odd      = (NSH % 2) != 0;
            for (int p = 0; p < 4; p++) begin
                a_sh[p] = (p < NSH) ? a_ext[BYTE_W*p +: BYTE_W] : 8'h00;
                b_sh[p] = (p < NSH) ? b_ext[BYTE_W*p +: BYTE_W] : 8'h00;
            end
            rnd_bits = rnd;
            rnd_pos  = 0;
            t0 = next_rand_byte();
            t1 = next_rand_byte();
            for (int p = 0; p < NSH; p++) begin
                acc = '0;
                for (int q = 0; q < half; q++) begin
                    if (q != half - 1 || !odd) begin
                        acc = acc ^ pair_term(a_sh[p], b_sh[2*q], b_sh[2*q+1], t0);
                    end else begin
                        acc = acc ^ triple_term(a_sh[p], b_sh[2*q], b_sh[2*q+1],
                                                b_sh[2*q+2], t0, t1);
                    end
                end
                packed_c[BYTE_W*p +: BYTE_W] = acc;
            end
            return packed_c[CW-1:0];
        endfunction

        function void note_request(logic [CW-1:0] a, logic [CW-1:0] b,
                                   logic [RAND_W-1:0] rnd);
            owed_q.push_back(masked_product(a, b, rnd));
        endfunction

        function void check_product(logic [CW-1:0] got);
            logic [CW-1:0] want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected c_shares, expected none, got %h", $time, got);
            end else begin
                want = owed_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: c_shares mismatch, expected %h, got %h",
                             $time, want, got);
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // -----------------------------------------------------------------------
    logic          aclk       = 1'b0;
    logic          aresetn    = 1'b0;
    logic          s_valid    = 1'b0;
    logic          s_ready;
    logic [CW-1:0] s_a_shares = '0;
    logic [CW-1:0] s_b_shares = '0;
    logic [63:0]   s_rand0    = '0;
    logic [63:0]   s_rand1    = '0;
    logic [63:0]   s_rand2    = '0;
    logic [63:0]   s_rand3    = '0;
    logic [63:0]   s_rand4    = '0;
    logic          m_valid;
    logic          m_ready    = 1'b0;
    logic [CW-1:0] m_c_shares;

    product_scoreboard board;
    int unsigned       quiet_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    masked_gf256_multiply #(.SHARES(NSH)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_a_shares (s_a_shares),
        .s_b_shares (s_b_shares),
        .s_rand0    (s_rand0),
        .s_rand1    (s_rand1),
        .s_rand2    (s_rand2),
        .s_rand3    (s_rand3),
        .s_rand4    (s_rand4),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_c_shares (m_c_shares)
    );

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Mostly back to back, some short gaps, the odd long one
    function automatic int unsigned next_gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Share bytes lean towards 00, 01, 80 and FF now and then
    function automatic logic [CW-1:0] random_shares();
        logic [CW-1:0] v;
        for (int p = 0; p < NSH; p++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: v[BYTE_W*p +: BYTE_W] = 8'h00;
                    1: v[BYTE_W*p +: BYTE_W] = 8'h01;
                    2: v[BYTE_W*p +: BYTE_W] = 8'h80;
                    default: v[BYTE_W*p +: BYTE_W] = 8'hFF;
                endcase
            end else begin
                v[BYTE_W*p +: BYTE_W] = 8'($urandom);
            end
        end
        return v;
    endfunction

    function automatic logic [RAND_W-1:0] random_mask_bytes();
        logic [RAND_W-1:0] v;
        for (int i = 0; i < RAND_W / 32; i++) begin
            v[32*i +: 32] = $urandom;
        end
        return v;
    endfunction

    // Present one request at this edge and hold it until it is taken.
    // Returns at the edge where the handshake completed.
    task automatic send_request(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                input logic [RAND_W-1:0] rnd);
        s_valid    <= 1'b1;
        s_a_shares <= a;
        s_b_shares <= b;
        s_rand0    <= rnd[0*64 +: 64];
        s_rand1    <= rnd[1*64 +: 64];
        s_rand2    <= rnd[2*64 +: 64];
        s_rand3    <= rnd[3*64 +: 64];
        s_rand4    <= rnd[4*64 +: 64];
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drop valid for a gap of length n; nothing is touched when n is zero so that a
    // following request keeps valid high without a second assignment
    task automatic hold_off(input int unsigned n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Lower valid and wait until every owed product has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // -----------------------------------------------------------------------
    // Monitors: values are read at the edge before any update of that edge
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_request(s_a_shares, s_b_shares,
                               {s_rand4, s_rand3, s_rand2, s_rand1, s_rand0});
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_product(m_c_shares);
        end
    end

    // Watchdog on cycles where neither channel moves a request
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: ready runs and stalls of random length, with occasional
    // long runs where the output is never held up
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                run_len = $urandom_range(100, 300);
            end else begin
                run_len = $urandom_range(1, 8);
            end
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = next_gap_length();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [CW-1:0]     a_val;
        logic [CW-1:0]     b_val;
        logic [RAND_W-1:0] rnd;
        board = new();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of shares and masks
        send_request('0, '0, '0);
        send_request('1, '1, '1);
        send_request('1, '0, random_mask_bytes());
        send_request('0, '1, random_mask_bytes());
        send_request({NSH{8'h01}}, random_shares(), '0);
        send_request({NSH{8'h80}}, {NSH{8'h80}}, random_mask_bytes());
        // 0x53 and 0xCA are inverses in the field
        send_request({NSH{8'h53}}, CW'(8'hCA), random_mask_bytes());
        send_request(CW'(8'h01), {8'h80, {(NSH-1){8'h00}}}, '1);
        // Only the unused top random word set: must not change anything
        a_val = random_shares();
        b_val = random_shares();
        send_request(a_val, b_val, {64'hFFFF_FFFF_FFFF_FFFF, {(RAND_W-64){1'b0}}});
        send_request(a_val, b_val, {64'($urandom) << 32 | 64'($urandom),
                                    {(RAND_W-64){1'b0}}});
        // Top-level remask bytes saturated, the rest random
        rnd = random_mask_bytes();
        rnd[15:0] = 16'hFFFF;
        send_request(random_shares(), random_shares(), rnd);
        // Alternating bit patterns across all fields
        send_request({(CW/2){2'b10}}, {(CW/2){2'b01}}, {(RAND_W/2){2'b10}});
        send_request({(CW/2){2'b01}}, {(CW/2){2'b10}}, {(RAND_W/2){2'b01}});
        hold_off(next_gap_length());

        // Random part, with a gap-free burst and a full drain midway
        for (int n = 0; n < RANDOM_REQS; n++) begin
            a_val = random_shares();
            b_val = random_shares();
            case ($urandom_range(0, 31))
                0:       rnd = '0;
                1:       rnd = '1;
                default: rnd = random_mask_bytes();
            endcase
            send_request(a_val, b_val, rnd);
            if (n == RANDOM_REQS / 2) begin
                drain_results();
            end else if (n < 200 || n >= 400) begin
                hold_off(next_gap_length());
            end
        end

        // Wait for the last products, then wait out DRAIN_WAIT for anything stray
        drain_results();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
